// ===== hdl/rmasg_pkg.sv =====
package rmasg_pkg;

  localparam int AXIS_COUNT = 4;
  localparam int AXIS_W     = 2;

  typedef logic [2:0] cmd_t;
  localparam cmd_t CMD_ADVANCE = 3'd0;
  localparam cmd_t CMD_START   = 3'd1;
  localparam cmd_t CMD_STOP    = 3'd2;
  localparam cmd_t CMD_ENABLE  = 3'd3;
  localparam cmd_t CMD_CLEAR   = 3'd4;

  typedef logic [1:0] status_t;
  localparam status_t STAT_OK       = 2'd0;
  localparam status_t STAT_DISABLED = 2'd1;
  localparam status_t STAT_IGNORED  = 2'd2;
  localparam status_t STAT_ABORTED  = 2'd3;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_RAMP_START = 2'd0;
  localparam reg_idx_t REG_ACCEL      = 2'd1;
  localparam reg_idx_t REG_DECEL      = 2'd2;

  localparam logic [2:0]  SEL_ALL        = 3'd4;
  localparam logic [12:0] DELAY_MIN      = 13'd20;
  localparam logic [12:0] DELAY_MAX      = 13'd5000;
  localparam logic [12:0] RAMP_START_RST = 13'd600;
  localparam logic [15:0] ACCEL_RST      = 16'd300;
  localparam logic [15:0] DECEL_RST      = 16'd300;
  localparam logic [31:0] SHAPE_LAST     = 32'd63;

  // For x below 2**21, x / 255 rounded down equals (x * SHAPE_RECIP) >> SHAPE_RECIP_SH.
  localparam logic [21:0] SHAPE_RECIP    = 22'd2105377;
  localparam int          SHAPE_RECIP_SH = 29;

  // Half-cosine ramp shape, 64 entries scaled to 0..255.
  localparam logic [7:0] SHAPE_TAB [64] = '{
    8'd0,   8'd0,   8'd1,   8'd1,   8'd3,   8'd4,   8'd6,   8'd8,
    8'd10,  8'd13,  8'd16,  8'd19,  8'd22,  8'd26,  8'd30,  8'd34,
    8'd38,  8'd43,  8'd48,  8'd53,  8'd58,  8'd64,  8'd69,  8'd75,
    8'd81,  8'd87,  8'd93,  8'd99,  8'd105, 8'd112, 8'd118, 8'd124,
    8'd131, 8'd137, 8'd143, 8'd150, 8'd156, 8'd162, 8'd168, 8'd174,
    8'd180, 8'd186, 8'd191, 8'd197, 8'd202, 8'd207, 8'd212, 8'd217,
    8'd221, 8'd225, 8'd229, 8'd233, 8'd236, 8'd239, 8'd242, 8'd245,
    8'd247, 8'd249, 8'd251, 8'd252, 8'd254, 8'd254, 8'd255, 8'd255
  };

endpackage

// ===== hdl/rmasg_if.sv =====
interface rmasg_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         command;
  logic signed [31:0] target_0;
  logic signed [31:0] target_1;
  logic signed [31:0] target_2;
  logic signed [31:0] target_3;
  logic [15:0]        cruise_us;
  logic               enable_value;
  logic [2:0]         axis_select;

  modport source (output valid, command, target_0, target_1, target_2, target_3,
                  cruise_us, enable_value, axis_select, input ready);
  modport sink (input valid, command, target_0, target_1, target_2, target_3,
                cruise_us, enable_value, axis_select, output ready);
endinterface

interface rmasg_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         step_mask;
  logic [3:0]         dir_mask;
  logic [12:0]        step_delay;
  logic               move_ended;
  logic [1:0]         status;
  logic               drives_on;
  logic signed [31:0] position_0;
  logic signed [31:0] position_1;
  logic signed [31:0] position_2;
  logic signed [31:0] position_3;

  modport source (output valid, step_mask, dir_mask, step_delay, move_ended, status,
                  drives_on, position_0, position_1, position_2, position_3,
                  input ready);
  modport sink (input valid, step_mask, dir_mask, step_delay, move_ended, status,
                drives_on, position_0, position_1, position_2, position_3,
                output ready);
endinterface

// ===== hdl/rmasg_div.sv =====
module rmasg_div #(
  parameter int DVD_W = 64,
  parameter int DSR_W = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DSR_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W);

  // Restoring divider, one quotient bit per cycle.
  logic [DSR_W-1:0] rem_r;
  logic [DVD_W-1:0] quo_r;
  logic [DSR_W-1:0] dsr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DSR_W:0]   rem_sh;
  logic             fits;
  logic [DSR_W:0]   rem_nxt;

  assign rem_sh  = {rem_r, quo_r[DVD_W-1]};
  assign fits    = rem_sh >= {1'b0, dsr_r};
  assign rem_nxt = fits ? rem_sh - {1'b0, dsr_r} : rem_sh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r  <= '0;
        quo_r  <= dividend;
        dsr_r  <= divisor;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= rem_nxt[DSR_W-1:0];
        quo_r <= {quo_r[DVD_W-2:0], fits};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== hdl/ramped_multi_axis_step_generator.sv =====
// Four-axis coordinated step generator. Each request is one command: advance one step, start a
// move, request a stop, set the drive enable or clear positions; every request gives exactly one
// result. A start latches absolute targets, picks the axis with the longest travel as master and
// plans a half-cosine speed ramp; each advance then runs one Bresenham step and reports the step
// and direction masks and the half-period delay. The work runs under a small sequencer around one
// shared product register and one 64-by-32 bit-serial divider; the ramp scale by 1/255 is a
// reciprocal multiplication. A ramp advance runs one division and an aborting advance runs one
// division per axis. The block takes a new request only after the previous result has been taken.
module ramped_multi_axis_step_generator (
  input  logic                 clk,
  input  logic                 rst_n,
  rmasg_in_if.sink             in_if,
  rmasg_out_if.source          out_if,
  input  logic                 cfg_we,
  input  rmasg_pkg::reg_idx_t  cfg_index,
  input  logic [15:0]          cfg_wdata
);
  import rmasg_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DONE, ST_ST_AX, ST_ST_FIN, ST_R_MUL1, ST_R_DIV1, ST_R_MUL2, ST_R_RCP,
    ST_R_APPLY, ST_BRES, ST_AB_MUL, ST_AB_DIV
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [12:0] ramp_start_r;
  logic [15:0] accel_r;
  logic [15:0] decel_r;

  // Move state.
  logic [31:0] pos_r   [AXIS_COUNT];
  logic [31:0] dist_r  [AXIS_COUNT];
  logic [31:0] err_r   [AXIS_COUNT];
  logic [31:0] tgt_r   [AXIS_COUNT];
  logic [31:0] in_tgt_r[AXIS_COUNT];
  logic [AXIS_COUNT-1:0] fwd_r;
  logic [31:0] total_r, index_r, rul_r, rdb_r;
  logic [12:0] cruise_r;
  logic        busy_r, stop_r, drv_r;

  // Request and result holding.
  logic [15:0]       cd_r;
  logic [AXIS_W-1:0] axis_r;
  logic [3:0]        smask_r;
  logic [12:0]       delay_r;
  logic              ended_r;
  status_t           status_r;
  logic              out_valid_r;

  // Shared arithmetic.
  logic [63:0] mul_r;
  logic [31:0] dsr_r;
  logic        div_go_r;
  logic        div_done;
  logic [63:0] div_quo;
  logic [7:0]  shape_r;
  logic        ph_up_r;

  logic        in_acc;
  logic        stop_hit;
  logic        down_ramp;
  logic [12:0] ramp_span;
  logic [32:0] diff;
  logic [32:0] mag;
  logic [32:0] err_sum;
  logic [16:0] ramp_sum;
  logic [31:0] up_len;
  logic [31:0] down_len;
  logic [12:0] cd_clamp;
  logic [12:0] ramp_q;
  logic [31:0] index_nxt;

  rmasg_div #(.DVD_W(64), .DSR_W(32)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go_r),
    .dividend (mul_r),
    .divisor  (dsr_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign in_acc = in_if.valid && in_if.ready;

  // A pending stop takes effect only on a cruise step on the 16-step grid.
  assign stop_hit = stop_r && (index_r > rul_r) && (index_r < rdb_r) && (index_r[3:0] == 4'd0);

  assign down_ramp = ramp_start_r >= cruise_r;
  assign ramp_span = down_ramp ? ramp_start_r - cruise_r : cruise_r - ramp_start_r;
  // Quotient of span * shape by 255, taken from the reciprocal product.
  assign ramp_q    = mul_r[SHAPE_RECIP_SH +: 13];

  assign diff    = {in_tgt_r[axis_r][31], in_tgt_r[axis_r]} - {pos_r[axis_r][31], pos_r[axis_r]};
  assign mag     = diff[32] ? 33'd0 - diff : diff;
  assign err_sum = {1'b0, err_r[axis_r]} + {1'b0, dist_r[axis_r]};

  // Short moves split their length between the two ramps.
  assign ramp_sum = {1'b0, accel_r} + {1'b0, decel_r};
  always_comb begin
    if (total_r < {15'd0, ramp_sum}) begin
      up_len   = {1'b0, total_r[31:1]};
      down_len = total_r - {1'b0, total_r[31:1]};
    end else begin
      up_len   = {16'd0, accel_r};
      down_len = {16'd0, decel_r};
    end
  end

  always_comb begin
    if (cd_r < {3'd0, DELAY_MIN}) begin
      cd_clamp = DELAY_MIN;
    end else if (cd_r > {3'd0, DELAY_MAX}) begin
      cd_clamp = DELAY_MAX;
    end else begin
      cd_clamp = cd_r[12:0];
    end
  end

  assign index_nxt = index_r + 32'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      ramp_start_r <= RAMP_START_RST;
      accel_r      <= ACCEL_RST;
      decel_r      <= DECEL_RST;
      for (int i = 0; i < AXIS_COUNT; i++) begin
        pos_r[i]  <= '0;
        dist_r[i] <= '0;
        err_r[i]  <= '0;
        tgt_r[i]  <= '0;
      end
      fwd_r       <= '0;
      total_r     <= '0;
      index_r     <= '0;
      rul_r       <= '0;
      rdb_r       <= '0;
      cruise_r    <= '0;
      busy_r      <= 1'b0;
      stop_r      <= 1'b0;
      drv_r       <= 1'b0;
      out_valid_r <= 1'b0;
      div_go_r    <= 1'b0;
    end else begin
      div_go_r <= 1'b0;
      if (out_if.valid && out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_RAMP_START: ramp_start_r <= cfg_wdata[12:0];
          REG_ACCEL:      accel_r      <= cfg_wdata;
          REG_DECEL:      decel_r      <= cfg_wdata;
          default: ;
        endcase
      end

      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            in_tgt_r[0] <= in_if.target_0;
            in_tgt_r[1] <= in_if.target_1;
            in_tgt_r[2] <= in_if.target_2;
            in_tgt_r[3] <= in_if.target_3;
            cd_r        <= in_if.cruise_us;
            axis_r      <= '0;
            smask_r     <= '0;
            delay_r     <= '0;
            ended_r     <= 1'b0;
            status_r    <= STAT_OK;
            state_r     <= ST_DONE;
            case (in_if.command)
              CMD_ADVANCE: begin
                if (!busy_r) begin
                  status_r <= STAT_IGNORED;
                end else if (!drv_r) begin
                  status_r <= STAT_DISABLED;
                end else if (stop_hit) begin
                  state_r <= ST_AB_MUL;
                end else if (index_r < rul_r || index_r >= rdb_r) begin
                  state_r <= ST_R_MUL1;
                end else begin
                  delay_r <= cruise_r;
                  state_r <= ST_BRES;
                end
              end
              CMD_START: begin
                if (busy_r) begin
                  status_r <= STAT_IGNORED;
                end else if (!drv_r) begin
                  status_r <= STAT_DISABLED;
                end else begin
                  total_r <= '0;
                  state_r <= ST_ST_AX;
                end
              end
              CMD_STOP: begin
                if (busy_r) begin
                  stop_r <= 1'b1;
                end else begin
                  status_r <= STAT_IGNORED;
                end
              end
              CMD_ENABLE: begin
                drv_r <= in_if.enable_value;
              end
              CMD_CLEAR: begin
                if (busy_r) begin
                  status_r <= STAT_IGNORED;
                end else if (in_if.axis_select == SEL_ALL) begin
                  for (int i = 0; i < AXIS_COUNT; i++) begin
                    pos_r[i] <= '0;
                  end
                end else if (in_if.axis_select < 3'(AXIS_COUNT)) begin
                  pos_r[in_if.axis_select[AXIS_W-1:0]] <= '0;
                end else begin
                  status_r <= STAT_IGNORED;
                end
              end
              default: begin
                status_r <= STAT_IGNORED;
              end
            endcase
          end
        end

        ST_ST_AX: begin
          tgt_r[axis_r]  <= in_tgt_r[axis_r];
          dist_r[axis_r] <= mag[31:0];
          fwd_r[axis_r]  <= !diff[32];
          err_r[axis_r]  <= '0;
          if (mag[31:0] > total_r) begin
            total_r <= mag[31:0];
          end
          axis_r <= axis_r + 1'b1;
          if (axis_r == AXIS_W'(AXIS_COUNT - 1)) begin
            state_r <= ST_ST_FIN;
          end
        end

        ST_ST_FIN: begin
          cruise_r <= cd_clamp;
          rul_r    <= up_len;
          rdb_r    <= total_r - down_len;
          index_r  <= '0;
          stop_r   <= 1'b0;
          if (total_r == '0) begin
            ended_r <= 1'b1;
          end else begin
            busy_r <= 1'b1;
          end
          state_r <= ST_DONE;
        end

        // Ramp position: idx = num * 63 / len.
        ST_R_MUL1: begin
          ph_up_r <= index_r < rul_r;
          if (index_r < rul_r) begin
            mul_r <= index_r * SHAPE_LAST;
            dsr_r <= rul_r;
          end else begin
            mul_r <= (index_r - rdb_r) * SHAPE_LAST;
            dsr_r <= total_r - rdb_r;
          end
          div_go_r <= 1'b1;
          state_r  <= ST_R_DIV1;
        end

        ST_R_DIV1: begin
          if (div_done) begin
            shape_r <= SHAPE_TAB[div_quo[5:0]];
            state_r <= ST_R_MUL2;
          end
        end

        ST_R_MUL2: begin
          mul_r   <= {51'd0, ramp_span} * {56'd0, shape_r};
          state_r <= ST_R_RCP;
        end

        // The span * shape product is below 2**21, so the reciprocal is exact.
        ST_R_RCP: begin
          mul_r   <= {43'd0, mul_r[20:0]} * {42'd0, SHAPE_RECIP};
          state_r <= ST_R_APPLY;
        end

        ST_R_APPLY: begin
          if (ph_up_r) begin
            delay_r <= down_ramp ? ramp_start_r - ramp_q : ramp_start_r + ramp_q;
          end else begin
            delay_r <= down_ramp ? cruise_r + ramp_q : cruise_r - ramp_q;
          end
          state_r <= ST_BRES;
        end

        // One Bresenham error update per axis per cycle.
        ST_BRES: begin
          if (err_sum >= {1'b0, total_r}) begin
            err_r[axis_r]   <= err_sum[31:0] - total_r;
            smask_r[axis_r] <= 1'b1;
          end else begin
            err_r[axis_r] <= err_sum[31:0];
          end
          axis_r <= axis_r + 1'b1;
          if (axis_r == AXIS_W'(AXIS_COUNT - 1)) begin
            index_r <= index_nxt;
            if (index_nxt >= total_r) begin
              for (int i = 0; i < AXIS_COUNT; i++) begin
                pos_r[i] <= tgt_r[i];
              end
              busy_r  <= 1'b0;
              stop_r  <= 1'b0;
              ended_r <= 1'b1;
            end
            state_r <= ST_DONE;
          end
        end

        // Abort: each axis moves by distance * steps_done / master_total.
        ST_AB_MUL: begin
          mul_r    <= {32'd0, dist_r[axis_r]} * {32'd0, index_r};
          dsr_r    <= total_r;
          div_go_r <= 1'b1;
          state_r  <= ST_AB_DIV;
        end

        ST_AB_DIV: begin
          if (div_done) begin
            pos_r[axis_r] <= fwd_r[axis_r] ? pos_r[axis_r] + div_quo[31:0]
                                           : pos_r[axis_r] - div_quo[31:0];
            axis_r <= axis_r + 1'b1;
            if (axis_r == AXIS_W'(AXIS_COUNT - 1)) begin
              drv_r    <= 1'b0;
              busy_r   <= 1'b0;
              stop_r   <= 1'b0;
              ended_r  <= 1'b1;
              status_r <= STAT_ABORTED;
              state_r  <= ST_DONE;
            end else begin
              state_r <= ST_AB_MUL;
            end
          end
        end

        ST_DONE: begin
          out_valid_r <= 1'b1;
          state_r     <= ST_IDLE;
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_if.ready = (state_r == ST_IDLE) && !out_valid_r;

  // The result fields come straight from the state registers, which hold still
  // until the result has been taken and the next request accepted.
  assign out_if.valid      = out_valid_r;
  assign out_if.step_mask  = smask_r;
  assign out_if.dir_mask   = fwd_r;
  assign out_if.step_delay = delay_r;
  assign out_if.move_ended = ended_r;
  assign out_if.status     = status_r;
  assign out_if.drives_on  = drv_r;
  assign out_if.position_0 = pos_r[0];
  assign out_if.position_1 = pos_r[1];
  assign out_if.position_2 = pos_r[2];
  assign out_if.position_3 = pos_r[3];

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_if.ready)
    else $error("request accepted while sequencer busy");

  a_busy_total: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (total_r != '0) && (index_r < total_r))
    else $error("active move with inconsistent step count");

  a_abort_off: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == STAT_ABORTED) |-> (!drv_r && !busy_r && ended_r))
    else $error("aborted move left drives or move active");

  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_go_r |=> (state_r == ST_R_DIV1 || state_r == ST_AB_DIV))
    else $error("division launched outside a wait state");

endmodule

// ===== test/step_gen_checker.sv =====
`timescale 1ns / 1ps

module step_gen_checker (
  input  logic                 clk,
  input  logic                 rst_n,
  rmasg_in_if                  in_mon,
  rmasg_out_if                 out_mon,
  input  logic                 cfg_we,
  input  rmasg_pkg::reg_idx_t  cfg_index,
  input  logic [15:0]          cfg_wdata,
  output int                   fail_count,
  output int                   pending_results
);
  import rmasg_pkg::*;

  typedef struct {
    logic [3:0]  step_mask;
    logic [3:0]  dir_mask;
    logic [12:0] step_delay;
    logic        move_ended;
    status_t     status;
    logic        drives_on;
    logic [31:0] pos [AXIS_COUNT];
  } step_result_t;

  step_result_t expected_steps [$];
  int nfail;

  // Own copy of the block's configuration and motion state.
  logic [12:0] ramp_start;
  logic [15:0] accel_len, decel_len;
  logic [31:0] pos [AXIS_COUNT];
  logic [31:0] axis_span [AXIS_COUNT];
  logic [31:0] err [AXIS_COUNT];
  logic [31:0] goal [AXIS_COUNT];
  logic        fwd [AXIS_COUNT];
  logic        drives, busy, stop_req;
  logic [31:0] total, step_idx, up_len, down_at;
  logic [12:0] cruise;

  function automatic logic [7:0] shape_pick(longint unsigned num, longint unsigned den);
    longint unsigned i;
    if (den == 0) return 8'd255;
    i = num * 63 / den;
    if (i > 63) i = 63;
    return SHAPE_TAB[i];
  endfunction

  function automatic logic [12:0] delay_for(logic [31:0] s);
    longint unsigned st, cr, r, q;
    bit dn;
    st = ramp_start;
    cr = cruise;
    dn = st >= cr;
    r = dn ? st - cr : cr - st;
    if (s < up_len) begin
      q = r * shape_pick(s, up_len) / 255;
      return dn ? st - q : st + q;
    end
    if (s >= down_at) begin
      q = r * shape_pick(s - down_at, total - down_at) / 255;
      return dn ? cr + q : cr - q;
    end
    return cr;
  endfunction

  task automatic predict_step(output step_result_t r);
    longint unsigned e, mag, big, up, dn, cd;
    longint signed tg, d;
    logic [31:0] s, done;
    logic signed [31:0] tv [AXIS_COUNT];
    r.step_mask = '0;
    r.step_delay = '0;
    r.move_ended = 1'b0;
    r.status = STAT_OK;
    tv[0] = in_mon.target_0;
    tv[1] = in_mon.target_1;
    tv[2] = in_mon.target_2;
    tv[3] = in_mon.target_3;
    case (in_mon.command)
      CMD_ADVANCE: begin
        if (!busy) r.status = STAT_IGNORED;
        else if (!drives) r.status = STAT_DISABLED;
        else begin
          s = step_idx;
          if (stop_req && s > up_len && s < down_at && s[3:0] == 4'd0) begin
            // Abort lands each axis in proportion to the master steps done.
            for (int i = 0; i < AXIS_COUNT; i++) begin
              done = (total != 0) ? 32'(longint'(axis_span[i]) * s / total) : 32'd0;
              pos[i] = fwd[i] ? pos[i] + done : pos[i] - done;
            end
            drives = 1'b0;
            busy = 1'b0;
            stop_req = 1'b0;
            r.move_ended = 1'b1;
            r.status = STAT_ABORTED;
          end else begin
            r.step_delay = delay_for(s);
            for (int i = 0; i < AXIS_COUNT; i++) begin
              e = longint'(err[i]) + axis_span[i];
              if (e >= total) begin
                e -= total;
                r.step_mask[i] = 1'b1;
              end
              err[i] = e[31:0];
            end
            step_idx = s + 1;
            if (step_idx >= total) begin
              for (int i = 0; i < AXIS_COUNT; i++) pos[i] = goal[i];
              busy = 1'b0;
              stop_req = 1'b0;
              r.move_ended = 1'b1;
            end
          end
        end
      end
      CMD_START: begin
        if (busy) r.status = STAT_IGNORED;
        else if (!drives) r.status = STAT_DISABLED;
        else begin
          big = 0;
          for (int i = 0; i < AXIS_COUNT; i++) begin
            tg = tv[i];
            d = tg - longint'($signed(pos[i]));
            mag = (d < 0) ? -d : d;
            goal[i] = tg[31:0];
            axis_span[i] = mag[31:0];
            fwd[i] = d >= 0;
            err[i] = '0;
            if (mag > big) big = mag;
          end
          cd = in_mon.cruise_us;
          if (cd < DELAY_MIN) cd = DELAY_MIN;
          if (cd > DELAY_MAX) cd = DELAY_MAX;
          cruise = cd[12:0];
          up = accel_len;
          dn = decel_len;
          // Short moves split their length between the two ramps.
          if (big < up + dn) begin
            up = big / 2;
            dn = big - up;
          end
          total = big[31:0];
          step_idx = '0;
          up_len = up[31:0];
          down_at = 32'(big - dn);
          stop_req = 1'b0;
          if (big == 0) r.move_ended = 1'b1;
          else busy = 1'b1;
        end
      end
      CMD_STOP: begin
        if (busy) stop_req = 1'b1;
        else r.status = STAT_IGNORED;
      end
      CMD_ENABLE: drives = in_mon.enable_value;
      CMD_CLEAR: begin
        if (busy) r.status = STAT_IGNORED;
        else if (in_mon.axis_select == SEL_ALL) begin
          for (int i = 0; i < AXIS_COUNT; i++) pos[i] = '0;
        end else if (in_mon.axis_select < AXIS_COUNT) pos[in_mon.axis_select] = '0;
        else r.status = STAT_IGNORED;
      end
      default: r.status = STAT_IGNORED;
    endcase
    for (int i = 0; i < AXIS_COUNT; i++) begin
      r.dir_mask[i] = fwd[i];
      r.pos[i] = pos[i];
    end
    r.drives_on = drives;
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      nfail++;
    end
  endtask

  always @(posedge clk) begin
    step_result_t want;
    logic [31:0] got_pos [AXIS_COUNT];
    if (!rst_n) begin
      ramp_start = RAMP_START_RST;
      accel_len = ACCEL_RST;
      decel_len = DECEL_RST;
      for (int i = 0; i < AXIS_COUNT; i++) begin
        pos[i] = '0;
        axis_span[i] = '0;
        err[i] = '0;
        goal[i] = '0;
        fwd[i] = 1'b0;
      end
      drives = 1'b0;
      busy = 1'b0;
      stop_req = 1'b0;
      total = '0;
      step_idx = '0;
      up_len = '0;
      down_at = '0;
      cruise = '0;
      expected_steps.delete();
      nfail = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_RAMP_START: ramp_start = cfg_wdata[12:0];
          REG_ACCEL:      accel_len = cfg_wdata;
          REG_DECEL:      decel_len = cfg_wdata;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        predict_step(want);
        expected_steps.push_back(want);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_steps.size() == 0) begin
          $error("result arrived with no request outstanding");
          nfail++;
        end else begin
          want = expected_steps.pop_front();
          got_pos[0] = out_mon.position_0;
          got_pos[1] = out_mon.position_1;
          got_pos[2] = out_mon.position_2;
          got_pos[3] = out_mon.position_3;
          check_field("step_mask", want.step_mask, out_mon.step_mask);
          check_field("dir_mask", want.dir_mask, out_mon.dir_mask);
          check_field("step_delay", want.step_delay, out_mon.step_delay);
          check_field("move_ended", want.move_ended, out_mon.move_ended);
          check_field("status", want.status, out_mon.status);
          check_field("drives_on", want.drives_on, out_mon.drives_on);
          for (int i = 0; i < AXIS_COUNT; i++)
            check_field($sformatf("position_%0d", i), want.pos[i], got_pos[i]);
        end
      end
    end
    pending_results <= expected_steps.size();
    fail_count <= nfail;
  end

endmodule

// ===== test/tb_ramped_multi_axis_step_generator.sv =====
`timescale 1ns / 1ps

module tb_ramped_multi_axis_step_generator;
  import rmasg_pkg::*;

  // One request as the sender drives it onto the input channel.
  typedef struct {
    cmd_t        cmd;
    logic [31:0] tgt [AXIS_COUNT];
    logic [15:0] cruise;
    logic        en;
    logic [2:0]  sel;
  } step_req_t;

  // Idle cycles after the last result before the ramp registers are rewritten.
  localparam int SETTLE_CYCLES = 400;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  reg_idx_t    cfg_index;
  logic [15:0] cfg_wdata;
  int          fail_count;
  int          pending_results;
  int          stall_left;
  bit          quiet;
  int          sent;

  rmasg_in_if  in_ch ();
  rmasg_out_if out_ch ();

  ramped_multi_axis_step_generator u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  step_gen_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The result side holds ready low for a random number of cycles after each
  // accepted result. In quiet phases it never stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else if (out_ch.valid && out_ch.ready) begin
      stall_left = quiet ? 0 : $urandom_range(0, 12);
      if (stall_left > 0) out_ch.ready <= 1'b0;
    end else if (!out_ch.ready) begin
      if (stall_left > 0) stall_left--;
      else out_ch.ready <= 1'b1;
    end
  end

  // Every field but the command is filled with random bits so that unused fields still toggle.
  function automatic step_req_t random_req(cmd_t c);
    step_req_t r;
    r.cmd = c;
    for (int i = 0; i < AXIS_COUNT; i++) r.tgt[i] = $urandom;
    r.cruise = $urandom;
    r.en = $urandom;
    r.sel = $urandom;
    return r;
  endfunction

  function automatic logic [31:0] near_zero(int span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  // Moves start from cleared positions, so small targets keep the master
  // length short and the number of advances needed low.
  function automatic step_req_t short_move(int span);
    step_req_t r;
    r = random_req(CMD_START);
    for (int i = 0; i < AXIS_COUNT; i++) r.tgt[i] = near_zero(span);
    return r;
  endfunction

  // The sender waits a random gap before each request. Valid is only lowered
  // when a gap follows, so back-to-back requests keep it high.
  task automatic send(step_req_t r);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.command      <= r.cmd;
    in_ch.target_0     <= r.tgt[0];
    in_ch.target_1     <= r.tgt[1];
    in_ch.target_2     <= r.tgt[2];
    in_ch.target_3     <= r.tgt[3];
    in_ch.cruise_us    <= r.cruise;
    in_ch.enable_value <= r.en;
    in_ch.axis_select  <= r.sel;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
  endtask

  task automatic send_cmd(cmd_t c);
    send(random_req(c));
  endtask

  task automatic send_enable(logic en);
    step_req_t r;
    r = random_req(CMD_ENABLE);
    r.en = en;
    send(r);
  endtask

  task automatic send_clear(logic [2:0] sel);
    step_req_t r;
    r = random_req(CMD_CLEAR);
    r.sel = sel;
    send(r);
  endtask

  // Drop valid, wait for every outstanding result, then let the block settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all three registers on consecutive cycles with the enable held.
  task automatic program_ramp(logic [12:0] ramp_begin, logic [15:0] accel,
                              logic [15:0] decel);
    cfg_we    <= 1'b1;
    cfg_index <= REG_RAMP_START;
    cfg_wdata <= {3'b000, ramp_begin};
    @(posedge clk);
    cfg_index <= REG_ACCEL;
    cfg_wdata <= accel;
    @(posedge clk);
    cfg_index <= REG_DECEL;
    cfg_wdata <= decel;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // A well-formed move: enable, clear, start, then enough advances to finish
  // it, with an occasional stop request or a brief drive disable mixed in.
  task automatic run_move();
    step_req_t r;
    int span, steps;
    span = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 60);
    send_enable(1'b1);
    send_clear(SEL_ALL);
    r = short_move(span);
    send(r);
    steps = 0;
    for (int i = 0; i < AXIS_COUNT; i++) begin
      if ($signed(r.tgt[i]) > steps) steps = $signed(r.tgt[i]);
      if (-$signed(r.tgt[i]) > steps) steps = -$signed(r.tgt[i]);
    end
    steps += $urandom_range(0, 2);
    for (int k = 0; k < steps; k++) begin
      if ($urandom_range(0, 39) == 0) send_cmd(CMD_STOP);
      if ($urandom_range(0, 59) == 0) begin
        send_enable(1'b0);
        send_cmd(CMD_ADVANCE);
        send_enable(1'b1);
      end
      send_cmd(CMD_ADVANCE);
    end
  endtask

  // Random commands, unknown codes included; starts are kept short so that a
  // stray start can never leave a move that would not finish.
  task automatic send_noise();
    step_req_t r;
    r = random_req(cmd_t'($urandom_range(0, 7)));
    if (r.cmd == CMD_START) r = short_move(20);
    send(r);
  endtask

  initial begin
    step_req_t r;
    logic [12:0] st;
    logic [15:0] ac, dc;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_RAMP_START;
    cfg_wdata = '0;
    quiet = 1'b0;
    sent = 0;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_ADVANCE;
    in_ch.target_0 = '0;
    in_ch.target_1 = '0;
    in_ch.target_2 = '0;
    in_ch.target_3 = '0;
    in_ch.cruise_us = '0;
    in_ch.enable_value = 1'b0;
    in_ch.axis_select = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. With the drives still off after reset, advance, stop
    // and start are refused; bad axis numbers and unknown codes are ignored.
    send_cmd(CMD_ADVANCE);
    send_cmd(CMD_STOP);
    send_cmd(CMD_START);
    send_clear(3'd7);
    send_clear(SEL_ALL + 3'd1);
    send_clear(3'd2);
    send_cmd(cmd_t'(CMD_CLEAR + 3'd1));
    send_cmd(cmd_t'(3'd7));
    send_enable(1'b1);
    // A start to the current position makes no move.
    r = random_req(CMD_START);
    for (int i = 0; i < AXIS_COUNT; i++) r.tgt[i] = '0;
    send(r);
    drain();

    // Shortest ramps, then a start to the extremes of the target range with
    // the cruise delay below its floor. A stop is honored at master step 16.
    program_ramp(DELAY_MIN, 16'd1, 16'd1);
    r = random_req(CMD_START);
    r.tgt[0] = 32'h8000_0000;
    r.tgt[1] = 32'h7fff_ffff;
    r.tgt[2] = 32'hffff_ffff;
    r.tgt[3] = 32'h0000_0001;
    r.cruise = 16'd0;
    send(r);
    send_clear(SEL_ALL);
    send_enable(1'b0);
    send_cmd(CMD_ADVANCE);
    send_enable(1'b1);
    send_cmd(CMD_STOP);
    repeat (18) send_cmd(CMD_ADVANCE);
    drain();

    // Phases of random work, each under its own ramp settings. Every phase
    // boundary holds the sender until every expected result has come back.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin st = DELAY_MAX; ac = 16'hffff; dc = 16'hffff; end
        1: begin st = DELAY_MIN; ac = 16'd1; dc = 16'd1; end
        2: begin st = RAMP_START_RST; ac = ACCEL_RST; dc = DECEL_RST; end
        default: begin
          st = $urandom_range(DELAY_MIN, DELAY_MAX);
          ac = $urandom_range(1, 40);
          dc = $urandom_range(1, 40);
        end
      endcase
      program_ramp(st, ac, dc);
      quiet = (phase % 3 == 2);
      while (sent < 40 + (phase + 1) * 70) begin
        if ($urandom_range(0, 9) < 7) run_move();
        else send_noise();
      end
      drain();
    end

    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
